FILE: sv/irc_tok_pkg.sv
// ----------------------------------------------------------------------------
// irc_tok_pkg
// shared constants and the result type of the irc message tokenizer
// ----------------------------------------------------------------------------
package irc_tok_pkg;

  // default bounds, handed down through the top level parameters
  localparam int MaxParamsDef  = 16;
  localparam int MaxTargetsDef = 16;

  // characters with a meaning in the message grammar
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChHash  = 8'h23;

  // field kind codes
  localparam logic [2:0] FkOrigName = 3'd0;
  localparam logic [2:0] FkOrigUser = 3'd1;
  localparam logic [2:0] FkOrigHost = 3'd2;
  localparam logic [2:0] FkCommand  = 3'd3;
  localparam logic [2:0] FkParam    = 3'd4;
  localparam logic [2:0] FkDelim    = 3'd5;

  // target kind codes
  localparam logic [2:0] TkNone    = 3'd0;
  localparam logic [2:0] TkLocal   = 3'd1;
  localparam logic [2:0] TkMask    = 3'd2;
  localparam logic [2:0] TkChannel = 3'd3;
  localparam logic [2:0] TkNick    = 3'd4;
  localparam logic [2:0] TkHost    = 3'd5;
  localparam logic [2:0] TkComma   = 3'd6;

  // one tagged result item
  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] field_kind;
    logic [3:0] param_index;
    logic [2:0] target_kind;
    logic [3:0] target_index;
    logic       message_end;
    logic [4:0] param_count;
    logic [4:0] target_count;
    logic       overflow;
  } irc_tok_res_t;

endpackage

FILE: sv/irc_tok_if.sv
// ----------------------------------------------------------------------------
// irc_tok_in_if / irc_tok_out_if
// valid/ready channels for raw message bytes and tagged result items
// ----------------------------------------------------------------------------
interface irc_tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface irc_tok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [2:0] field_kind;
  logic [3:0] param_index;
  logic [2:0] target_kind;
  logic [3:0] target_index;
  logic       message_end;
  logic [4:0] param_count;
  logic [4:0] target_count;
  logic       overflow;

  modport source (
    output valid, output byte_out, output field_kind, output param_index,
    output target_kind, output target_index, output message_end,
    output param_count, output target_count, output overflow, input ready
  );
  modport sink (
    input valid, input byte_out, input field_kind, input param_index,
    input target_kind, input target_index, input message_end,
    input param_count, input target_count, input overflow, output ready
  );
endinterface

FILE: sv/irc_message_tokenizer_core.sv
// ----------------------------------------------------------------------------
// irc_message_tokenizer_core
// tags each byte of an irc message line by field, parameter and target
// ----------------------------------------------------------------------------
// an accepted item passes the input register and then the result register
// throughput: one item per cycle while the receiver does not stall the result channel
// the input register takes a new item while a result waits downstream only if it is empty
// reset: asynchronous, active low; clears both stage valids and parse state
module irc_message_tokenizer_core import irc_tok_pkg::*; #(
  parameter int MAX_PARAMS  = MaxParamsDef,
  parameter int MAX_TARGETS = MaxTargetsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  irc_tok_in_if.sink    in_i,
  irc_tok_out_if.source out_o
);

  // input register stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // result register stage
  logic         out_valid_q;
  irc_tok_res_t res_q;
  irc_tok_res_t res_d;

  // item moves from the input register into the result register
  logic advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // tagging and parse state, committed only when the item advances
  irc_tok_parser #(
    .MAX_PARAMS  (MAX_PARAMS),
    .MAX_TARGETS (MAX_TARGETS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // result channel
  assign out_o.valid        = out_valid_q;
  assign out_o.byte_out     = res_q.byte_out;
  assign out_o.field_kind   = res_q.field_kind;
  assign out_o.param_index  = res_q.param_index;
  assign out_o.target_kind  = res_q.target_kind;
  assign out_o.target_index = res_q.target_index;
  assign out_o.message_end  = res_q.message_end;
  assign out_o.param_count  = res_q.param_count;
  assign out_o.target_count = res_q.target_count;
  assign out_o.overflow     = res_q.overflow;

endmodule

FILE: sv/irc_tok_parser.sv
// ----------------------------------------------------------------------------
// irc_tok_parser
// parse state registers and the per-byte tagging logic
// ----------------------------------------------------------------------------
module irc_tok_parser import irc_tok_pkg::*; #(
  parameter int MAX_PARAMS  = MaxParamsDef,
  parameter int MAX_TARGETS = MaxTargetsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output irc_tok_res_t res_o
);

  localparam int PCW = $clog2(MAX_PARAMS + 1);
  localparam int TCW = $clog2(MAX_TARGETS + 1);
  localparam int PiMax = (MAX_PARAMS - 1 < 15) ? MAX_PARAMS - 1 : 15;
  localparam int TiMax = (MAX_TARGETS - 1 < 15) ? MAX_TARGETS - 1 : 15;

  localparam logic [3:0] PhStart   = 4'd0;
  localparam logic [3:0] PhOName   = 4'd1;
  localparam logic [3:0] PhOUser   = 4'd2;
  localparam logic [3:0] PhOHost   = 4'd3;
  localparam logic [3:0] PhOSpace  = 4'd4;
  localparam logic [3:0] PhCmd     = 4'd5;
  localparam logic [3:0] PhPSkip   = 4'd6;
  localparam logic [3:0] PhPNormal = 4'd7;
  localparam logic [3:0] PhPTrail  = 4'd8;

  logic [3:0]     ph_q, ph_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic [TCW-1:0] tc_q, tc_d;
  logic [2:0]     ctk_q, ctk_d;
  logic           ats_q, ats_d;
  logic           te_q, te_d;
  logic           ov_q, ov_d;
  logic           fp_q, fp_d;

  always_comb begin
    logic       do_start;
    logic       do_param;
    logic [7:0] pc_ext;
    logic [7:0] tc_ext;
    logic [7:0] pm1;
    logic [7:0] tm1;

    ph_d  = ph_q;
    pc_d  = pc_q;
    tc_d  = tc_q;
    ctk_d = ctk_q;
    ats_d = ats_q;
    te_d  = te_q;
    ov_d  = ov_q;
    fp_d  = fp_q;
    do_start = 1'b0;
    do_param = 1'b0;
    pc_ext = 8'(pc_q);
    pm1    = '0;
    tm1    = '0;

    res_o              = '0;
    res_o.byte_out     = byte_i;
    res_o.field_kind   = FkDelim;
    res_o.target_kind  = TkNone;
    res_o.message_end  = last_i;

    unique case (ph_q)
      PhStart: begin
        if (byte_i == ChColon) begin
          res_o.field_kind = FkOrigName;
          ph_d = PhOName;
        end else if (byte_i == ChSpace) begin
          ph_d = PhPSkip;
        end else begin
          res_o.field_kind = FkCommand;
          ph_d = PhCmd;
        end
      end
      PhOName: begin
        if (byte_i == ChBang) ph_d = PhOUser;
        else if (byte_i == ChAt) ph_d = PhOHost;
        else if (byte_i == ChSpace) ph_d = PhOSpace;
        else res_o.field_kind = FkOrigName;
      end
      PhOUser: begin
        if (byte_i == ChAt) ph_d = PhOHost;
        else if (byte_i == ChSpace) ph_d = PhOSpace;
        else res_o.field_kind = FkOrigUser;
      end
      PhOHost: begin
        if (byte_i == ChSpace) ph_d = PhOSpace;
        else res_o.field_kind = FkOrigHost;
      end
      PhOSpace, PhCmd: begin
        if (byte_i == ChSpace) begin
          if (ph_q == PhCmd) ph_d = PhPSkip;
        end else begin
          res_o.field_kind = FkCommand;
          ph_d = PhCmd;
        end
      end
      PhPSkip: begin
        if (byte_i == ChSpace) begin
          res_o.field_kind = FkDelim;
        end else if (byte_i == ChColon) begin
          // ':' opening the trailing parameter carries the index it will get
          res_o.param_index = (pc_ext < 8'(PiMax)) ? pc_ext[3:0] : 4'(PiMax);
          te_d = 1'b1;
          ph_d = PhPTrail;
        end else begin
          do_start = 1'b1;
          do_param = 1'b1;
          ph_d = PhPNormal;
        end
      end
      PhPNormal: begin
        if (byte_i == ChSpace) ph_d = PhPSkip;
        else do_param = 1'b1;
      end
      default: begin
        // trailing parameter: counted only once a byte follows the colon
        if (te_q) begin
          do_start = 1'b1;
          te_d = 1'b0;
        end
        do_param = 1'b1;
        ph_d = PhPTrail;
      end
    endcase

    if (do_start) begin
      if (8'(pc_d) < 8'(MAX_PARAMS)) begin
        fp_d = (pc_d == '0);
        pc_d = pc_d + PCW'(1);
      end else begin
        ov_d = 1'b1;
        fp_d = 1'b0;
      end
      ats_d = 1'b1;
      ctk_d = TkNone;
    end

    if (do_param) begin
      res_o.field_kind = FkParam;
      pm1 = 8'(pc_d) - 8'd1;
      res_o.param_index = (pm1 < 8'(PiMax)) ? pm1[3:0] : 4'(PiMax);
      if (fp_d) begin
        if (ats_d) begin
          if (8'(tc_d) < 8'(MAX_TARGETS)) tc_d = tc_d + TCW'(1);
          else ov_d = 1'b1;
          ats_d = 1'b0;
          case (byte_i)
            ChAmp:    ctk_d = TkLocal;
            ChDollar: ctk_d = TkMask;
            ChHash:   ctk_d = TkChannel;
            ChAt:     ctk_d = TkHost;
            default:  ctk_d = TkNick;
          endcase
        end else if (ctk_d == TkNick && byte_i == ChAt) begin
          ctk_d = TkHost;
        end
        tm1 = 8'(tc_d) - 8'd1;
        res_o.target_index = (tm1 < 8'(TiMax)) ? tm1[3:0] : 4'(TiMax);
        if (byte_i == ChComma) begin
          res_o.target_kind = TkComma;
          ats_d = 1'b1;
        end else begin
          res_o.target_kind = ctk_d;
        end
      end
    end

    pc_ext = 8'(pc_d);
    tc_ext = 8'(tc_d);
    if (last_i) begin
      res_o.param_count  = (pc_ext < 8'd31) ? pc_ext[4:0] : 5'd31;
      res_o.target_count = (tc_ext < 8'd31) ? tc_ext[4:0] : 5'd31;
      res_o.overflow     = ov_d;
      ph_d  = PhStart;
      pc_d  = '0;
      tc_d  = '0;
      ctk_d = TkNone;
      ats_d = 1'b1;
      te_d  = 1'b0;
      ov_d  = 1'b0;
      fp_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhStart;
      pc_q  <= '0;
      tc_q  <= '0;
      ctk_q <= TkNone;
      ats_q <= 1'b1;
      te_q  <= 1'b0;
      ov_q  <= 1'b0;
      fp_q  <= 1'b0;
    end else if (advance_i) begin
      ph_q  <= ph_d;
      pc_q  <= pc_d;
      tc_q  <= tc_d;
      ctk_q <= ctk_d;
      ats_q <= ats_d;
      te_q  <= te_d;
      ov_q  <= ov_d;
      fp_q  <= fp_d;
    end
  end

endmodule

FILE: verif/irc_tok_tag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_tok_tag_checker
// watches both channels, predicts the tag of every accepted byte and
// compares each result item with the oldest prediction
// ----------------------------------------------------------------------------
module irc_tok_tag_checker import irc_tok_pkg::*; #(
  parameter int MAX_PARAMS  = MaxParamsDef,
  parameter int MAX_TARGETS = MaxTargetsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  irc_tok_in_if  in_mon_i,
  irc_tok_out_if out_mon_i,
  output int     mismatch_count_o,
  output int     pending_count_o,
  output int     result_count_o,
  output int     message_count_o,
  output int     bound_hit_count_o
);

  typedef enum logic [3:0] {
    PhStart, PhOrigName, PhOrigUser, PhOrigHost, PhOrigSpace,
    PhCommand, PhParamSkip, PhParamWord, PhParamTrail
  } tok_phase_e;

  tok_phase_e   phase;
  int           n_params;
  int           n_targets;
  logic [2:0]   tgt_kind;
  logic         tgt_open;
  logic         trail_pending;
  logic         bound_hit;
  logic         first_param;

  irc_tok_res_t tag_q[$];
  irc_tok_res_t got;
  irc_tok_res_t want;

  assign pending_count_o = tag_q.size();

  function automatic void clear_parser();
    phase         = PhStart;
    n_params      = 0;
    n_targets     = 0;
    tgt_kind      = TkNone;
    tgt_open      = 1'b1;
    trail_pending = 1'b0;
    bound_hit     = 1'b0;
    first_param   = 1'b0;
  endfunction

  function automatic logic [3:0] clamp_index(int v, int bound);
    int top_v;
    top_v = bound - 1;
    if (top_v > 15) top_v = 15;
    return (v < top_v) ? 4'(v) : 4'(top_v);
  endfunction

  function automatic logic [4:0] clamp_count(int v);
    return (v < 31) ? 5'(v) : 5'd31;
  endfunction

  function automatic void open_param();
    if (n_params < MAX_PARAMS) begin
      first_param = (n_params == 0);
      n_params++;
    end else begin
      bound_hit   = 1'b1;
      first_param = 1'b0;
    end
    tgt_open = 1'b1;
    tgt_kind = TkNone;
  endfunction

  // parameter byte, with target split inside parameter 0
  function automatic void tag_param_byte(input logic [7:0] c, inout irc_tok_res_t r);
    r.field_kind  = FkParam;
    r.param_index = clamp_index(n_params - 1, MAX_PARAMS);
    if (first_param) begin
      if (tgt_open) begin
        if (n_targets < MAX_TARGETS) n_targets++;
        else bound_hit = 1'b1;
        tgt_open = 1'b0;
        case (c)
          ChAmp:    tgt_kind = TkLocal;
          ChDollar: tgt_kind = TkMask;
          ChHash:   tgt_kind = TkChannel;
          ChAt:     tgt_kind = TkHost;
          default:  tgt_kind = TkNick;
        endcase
      end else if (tgt_kind == TkNick && c == ChAt) begin
        tgt_kind = TkHost;
      end
      r.target_index = clamp_index(n_targets - 1, MAX_TARGETS);
      if (c == ChComma) begin
        r.target_kind = TkComma;
        tgt_open      = 1'b1;
      end else begin
        r.target_kind = tgt_kind;
      end
    end
  endfunction

  function automatic irc_tok_res_t tag_byte(input logic [7:0] c, input logic last);
    irc_tok_res_t r;
    r             = '0;
    r.byte_out    = c;
    r.field_kind  = FkDelim;
    r.message_end = last;
    case (phase)
      PhStart: begin
        if (c == ChColon) begin
          r.field_kind = FkOrigName;
          phase        = PhOrigName;
        end else if (c == ChSpace) begin
          phase = PhParamSkip;
        end else begin
          r.field_kind = FkCommand;
          phase        = PhCommand;
        end
      end
      PhOrigName: begin
        if (c == ChBang) phase = PhOrigUser;
        else if (c == ChAt) phase = PhOrigHost;
        else if (c == ChSpace) phase = PhOrigSpace;
        else r.field_kind = FkOrigName;
      end
      PhOrigUser: begin
        if (c == ChAt) phase = PhOrigHost;
        else if (c == ChSpace) phase = PhOrigSpace;
        else r.field_kind = FkOrigUser;
      end
      PhOrigHost: begin
        if (c == ChSpace) phase = PhOrigSpace;
        else r.field_kind = FkOrigHost;
      end
      PhOrigSpace, PhCommand: begin
        if (c == ChSpace) begin
          if (phase == PhCommand) phase = PhParamSkip;
        end else begin
          r.field_kind = FkCommand;
          phase        = PhCommand;
        end
      end
      PhParamSkip: begin
        if (c == ChColon) begin
          r.param_index = clamp_index(n_params, MAX_PARAMS);
          trail_pending = 1'b1;
          phase         = PhParamTrail;
        end else if (c != ChSpace) begin
          open_param();
          tag_param_byte(c, r);
          phase = PhParamWord;
        end
      end
      PhParamWord: begin
        if (c == ChSpace) phase = PhParamSkip;
        else tag_param_byte(c, r);
      end
      default: begin
        if (trail_pending) begin
          open_param();
          trail_pending = 1'b0;
        end
        tag_param_byte(c, r);
      end
    endcase
    if (last) begin
      r.param_count  = clamp_count(n_params);
      r.target_count = clamp_count(n_targets);
      r.overflow     = bound_hit;
      message_count_o++;
      if (bound_hit) bound_hit_count_o++;
      clear_parser();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
    mismatch_count_o++;
    if (mismatch_count_o <= 40)
      $display("%0t checker: %s on result %0d, got %0h expected %0h",
               $realtime, what, result_count_o, got_v, want_v);
  endtask

  task automatic check_field(input string name, input logic [7:0] got_v,
                             input logic [7:0] want_v);
    if (got_v !== want_v) report_mismatch({name, " differs"}, got_v, want_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      tag_q.delete();
      mismatch_count_o  = 0;
      result_count_o    = 0;
      message_count_o   = 0;
      bound_hit_count_o = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.byte_out     = out_mon_i.byte_out;
        got.field_kind   = out_mon_i.field_kind;
        got.param_index  = out_mon_i.param_index;
        got.target_kind  = out_mon_i.target_kind;
        got.target_index = out_mon_i.target_index;
        got.message_end  = out_mon_i.message_end;
        got.param_count  = out_mon_i.param_count;
        got.target_count = out_mon_i.target_count;
        got.overflow     = out_mon_i.overflow;
        if (tag_q.size() == 0) begin
          report_mismatch("result with nothing expected", got.byte_out, 8'h00);
        end else begin
          want = tag_q.pop_front();
          check_field("byte_out", got.byte_out, want.byte_out);
          check_field("field_kind", 8'(got.field_kind), 8'(want.field_kind));
          check_field("param_index", 8'(got.param_index), 8'(want.param_index));
          check_field("target_kind", 8'(got.target_kind), 8'(want.target_kind));
          check_field("target_index", 8'(got.target_index), 8'(want.target_index));
          check_field("message_end", 8'(got.message_end), 8'(want.message_end));
          check_field("param_count", 8'(got.param_count), 8'(want.param_count));
          check_field("target_count", 8'(got.target_count), 8'(want.target_count));
          check_field("overflow", 8'(got.overflow), 8'(want.overflow));
        end
        result_count_o++;
      end
      if (in_mon_i.valid && in_mon_i.ready)
        tag_q.push_back(tag_byte(in_mon_i.data_byte, in_mon_i.last_byte));
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives irc message lines byte by byte into the tokenizer under several
// idling patterns; the tag checker beside the block does the comparing
// ----------------------------------------------------------------------------
module tb_top import irc_tok_pkg::*; ();

  // cycles with no item moving on either channel before the run is abandoned
  localparam int StallLimit  = 2000;
  localparam int TargetBytes = 1850;
  // bytes sent between changes of idling pattern
  localparam int PhaseBytes  = 230;

  logic clk_i;
  logic rst_ni;

  irc_tok_in_if  in_if ();
  irc_tok_out_if out_if ();

  int mismatches;
  int pending;
  int results;
  int messages;
  int bound_hits;

  int snd_idle_pct;
  int rcv_stall_pct;
  int bytes_sent;
  int quiet_cycles;

  logic [7:0] msg_q[$];

  irc_message_tokenizer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  irc_tok_tag_checker u_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_mon_i          (in_if),
    .out_mon_i         (out_if),
    .mismatch_count_o  (mismatches),
    .pending_count_o   (pending),
    .result_count_o    (results),
    .message_count_o   (messages),
    .bound_hit_count_o (bound_hits)
  );

  always #5 clk_i = ~clk_i;

  // receiver side: random back-pressure at the current stall rate
  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= rcv_stall_pct);
  end

  // watchdog: gives up once nothing has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("tb_top: timeout, %0d results still outstanding", pending);
        $display("tb_top: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // idling pattern: none, sender only, receiver only, both lightly
  task automatic set_idling(input int sel);
    case (sel)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 72; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 72; end
      default: begin snd_idle_pct = 18; rcv_stall_pct = 18; end
    endcase
  endtask

  // one byte item; random gaps first, then hold until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  // hold the sender off until every predicted result has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) msg_q.push_back(s[i]);
  endtask

  // mostly letters, some grammar characters, now and then any byte at all
  function automatic logic [7:0] word_char(input bit space_ok);
    int         r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 65) begin
      c = 8'h61 + 8'($urandom_range(25));
    end else if (r < 85) begin
      case ($urandom_range(6))
        0:       c = ChColon;
        1:       c = ChBang;
        2:       c = ChAt;
        3:       c = ChComma;
        4:       c = ChAmp;
        5:       c = ChDollar;
        default: c = ChHash;
      endcase
    end else begin
      c = 8'($urandom_range(255));
    end
    if (c == ChSpace && !space_ok) c = 8'h5f;
    return c;
  endfunction

  task automatic push_word(input int len, input bit space_ok);
    repeat (len) msg_q.push_back(word_char(space_ok));
  endtask

  // comma list for parameter 0, every target kind plus empty ones
  task automatic push_targets(input int n_tgt);
    for (int t = 0; t < n_tgt; t++) begin
      if (t > 0) msg_q.push_back(ChComma);
      case ($urandom_range(5))
        0: begin msg_q.push_back(ChAmp);    push_word($urandom_range(1, 3), 0); end
        1: begin msg_q.push_back(ChDollar); push_word($urandom_range(0, 3), 0); end
        2: begin msg_q.push_back(ChHash);   push_word($urandom_range(1, 3), 0); end
        3: begin msg_q.push_back(ChAt);     push_word($urandom_range(0, 3), 0); end
        4: begin
          // nick, sometimes with a host part
          push_word($urandom_range(1, 3), 0);
          if ($urandom_range(1)) begin
            msg_q.push_back(ChAt);
            push_word($urandom_range(1, 3), 0);
          end
        end
        default: ; // empty target
      endcase
    end
  endtask

  task automatic build_message();
    int n_par;
    int n_tgt;
    msg_q.delete();
    if ($urandom_range(99) < 25) begin
      // noise: short runs of arbitrary bytes, spaces and colons included
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(1)) msg_q.push_back(8'($urandom_range(255)));
        else if ($urandom_range(2) == 0) msg_q.push_back(ChSpace);
        else msg_q.push_back(word_char(1));
      end
      return;
    end
    // origin prefix
    if ($urandom_range(1)) begin
      msg_q.push_back(ChColon);
      push_word($urandom_range(1, 5), 0);
      if ($urandom_range(1)) begin
        msg_q.push_back(ChBang);
        push_word($urandom_range(0, 4), 0);
      end
      if ($urandom_range(1)) begin
        msg_q.push_back(ChAt);
        push_word($urandom_range(0, 5), 0);
      end
      msg_q.push_back(ChSpace);
    end
    // command, occasionally left empty
    if ($urandom_range(9) != 0) push_word($urandom_range(1, 6), 0);
    // parameter list, a few running past the bound
    n_par = ($urandom_range(99) < 6) ? $urandom_range(15, 20) : $urandom_range(0, 5);
    n_tgt = ($urandom_range(99) < 6) ? $urandom_range(15, 20) : $urandom_range(1, 4);
    for (int p = 0; p < n_par; p++) begin
      msg_q.push_back(ChSpace);
      if ($urandom_range(7) == 0) msg_q.push_back(ChSpace);
      if (p == 0) push_targets(n_tgt);
      else push_word($urandom_range(1, 4), 0);
    end
    // trailing parameter, sometimes empty
    if ($urandom_range(99) < 40) begin
      msg_q.push_back(ChSpace);
      msg_q.push_back(ChColon);
      push_word($urandom_range(0, 6), 1);
    end
    if (msg_q.size() == 0) msg_q.push_back(8'h61);
  endtask

  initial begin
    int next_switch;
    int sel;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    bytes_sent      = 0;
    set_idling(0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full origin, every target kind, empty target, empty trailing
    msg_q.delete();
    push_text(":a!u@h P &,,$,#c,n@h,@ :");
    send_message();
    // leading space, then zero and all-ones bytes as parameter data
    msg_q.delete();
    msg_q.push_back(ChSpace);
    msg_q.push_back(8'h00);
    msg_q.push_back(8'hff);
    send_message();
    // a lone colon as a whole message
    msg_q.delete();
    msg_q.push_back(ChColon);
    send_message();
    drain();

    // random messages, cycling through the idling patterns twice
    sel         = 0;
    next_switch = bytes_sent + PhaseBytes;
    while (bytes_sent < TargetBytes) begin
      if (bytes_sent >= next_switch) begin
        drain();
        sel = (sel + 1) % 4;
        set_idling(sel);
        next_switch = bytes_sent + PhaseBytes;
      end
      build_message();
      send_message();
    end

    // let the pipeline empty, then a little margin for the two stages
    drain();
    repeat (8) @(posedge clk_i);

    $display("tb_top: %0d bytes in %0d messages, %0d result items checked",
             bytes_sent, messages, results);
    $display("tb_top: %0d messages ran past a bound, idling none/sender/receiver/both",
             bound_hits);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
